// ----- rtl/ppi_pkg.sv -----
// Package for the planar pose integrator: sequencer states, register indexes,
// fixed-point constants and the CORDIC arctangent table. No dependencies.
package ppi_pkg;

    typedef enum logic [3:0] {
        S_IDLE, S_TD, S_HD, S_HACC, S_ROT, S_CF, S_SS, S_SF, S_CS,
        S_XD, S_YD, S_ZD, S_CLAMP, S_HALF, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        REG_MIN_X  = 3'd0,
        REG_MAX_X  = 3'd1,
        REG_MIN_Y  = 3'd2,
        REG_MAX_Y  = 3'd3,
        REG_MIN_Z  = 3'd4,
        REG_MAX_Z  = 3'd5,
        REG_HOME_Z = 3'd6,
        REG_NONE   = 3'd7
    } reg_index_t;

    localparam logic [14:0]        DT_DEFAULT    = 15'd3277;
    localparam logic [15:0]        DT_LIMIT      = 16'd16384;
    localparam logic signed [15:0] HOME_LEVEL    = 16'sd2048;
    localparam logic signed [26:0] TURN_TO_ANGLE = 27'sd42722830;
    localparam logic signed [33:0] CORDIC_GAIN   = 34'sd652032874;
    localparam int                 CORDIC_STEPS  = 16;

    function automatic logic signed [33:0] ppi_atan(input logic [3:0] idx);
        logic signed [33:0] r;
        begin
            r = '0;
            case (idx)
                4'd0:  r = 34'sh20000000;
                4'd1:  r = 34'sh12E4051D;
                4'd2:  r = 34'sh09FB385B;
                4'd3:  r = 34'sh051111D4;
                4'd4:  r = 34'sh028B0D43;
                4'd5:  r = 34'sh0145D7E1;
                4'd6:  r = 34'sh00A2F61E;
                4'd7:  r = 34'sh00517C55;
                4'd8:  r = 34'sh0028BE53;
                4'd9:  r = 34'sh00145F2E;
                4'd10: r = 34'sh000A2F98;
                4'd11: r = 34'sh000517CC;
                4'd12: r = 34'sh00028BE6;
                4'd13: r = 34'sh000145F3;
                4'd14: r = 34'sh0000A2F9;
                default: r = 34'sh0000517C;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/ppi_cordic.sv -----
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with Q1.14
// rounding and clamping of the results. Depends on ppi_pkg.
module ppi_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [33:0] angle,
    output logic               done,
    output logic signed [15:0] sin_q,
    output logic signed [15:0] cos_q
);
    import ppi_pkg::*;

    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [33:0] dx, dy;

    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
        logic signed [33:0] s;
        logic signed [17:0] r;
        begin
            s = v + 34'sd32768;
            r = s[33:16];
            if (r > 18'sd16384)
                r = 18'sd16384;
            else if (r < -18'sd16384)
                r = -18'sd16384;
            return r[15:0];
        end
    endfunction

    always_comb
    begin
        dx = y_reg >>> cnt_reg;
        dy = x_reg >>> cnt_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next = CORDIC_GAIN;
            y_next = '0;
            z_next = angle;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - ppi_atan(cnt_reg);
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + ppi_atan(cnt_reg);
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign sin_q = to_q14(y_reg);
    assign cos_q = to_q14(x_reg);

endmodule

// ----- rtl/planar_pose_integrator.sv -----
// Top level of the planar pose integrator: handshakes, configuration
// registers, shared multiplier and the sequencer. Depends on ppi_pkg, ppi_cordic.
//
// A command item is taken in idle and starts no sequence. A tick item makes
// nine passes through one shared 32x27 multiplier and two 16-step CORDIC
// runs (full heading, then half heading); the block accepts no item until
// the result item has been taken on the output channel.
module planar_pose_integrator #(
    parameter logic signed [15:0] HOME_X = 16'sd0,
    parameter logic signed [15:0] HOME_Y = 16'sd0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic signed [15:0] vel_fwd,
    input  logic signed [15:0] vel_side,
    input  logic signed [15:0] vel_up,
    input  logic signed [15:0] turn_rate,
    input  logic signed [15:0] roll_rate,
    input  logic        [15:0] elapsed,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] pos_z,
    output logic        [15:0] heading_out,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [2:0]  cfg_index,
    input  logic signed [15:0] cfg_data
);
    import ppi_pkg::*;

    state_t state_reg, state_next;

    logic signed [15:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [15:0] min_z_reg, max_z_reg, home_z_reg;
    logic signed [15:0] fwd_reg, side_reg, up_reg, turn_reg;
    logic               home_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic        [31:0] head_reg, head_next;
    logic        [14:0] dt_reg;
    logic signed [31:0] vx_reg, vy_reg;
    logic signed [33:0] sx_reg, sy_reg;
    logic signed [15:0] sn_reg, cs_reg;
    logic               neg_reg;

    logic signed [31:0] mul_a;
    logic signed [26:0] mul_b;
    logic signed [58:0] prod_reg;
    logic signed [58:0] prod_rnd24, prod_rnd14;
    logic signed [33:0] pz_sum, ang_full, ang_half;
    logic               fold_hi, fold_lo;
    logic signed [15:0] c_sin, c_cos;
    logic               cordic_start;
    logic               cordic_done;
    logic signed [33:0] cordic_angle;

    function automatic logic signed [31:0] clamp_axis(input logic signed [33:0] p,
                                                     input logic signed [15:0] lo,
                                                     input logic signed [15:0] hi);
        logic signed [33:0] l, u;
        logic signed [31:0] r;
        begin
            l = {{2{lo[15]}}, lo, 16'd0};
            u = {{2{hi[15]}}, hi, 16'd0};
            if (p < l)
                r = l[31:0];
            else if (p > u)
                r = u[31:0];
            else
                r = p[31:0];
            return r;
        end
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign cfg_ready = 1'b1;

    // Shared multiplier with a registered product.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_TD:    begin mul_a = 32'(turn_reg);     mul_b = 27'($signed({1'b0, dt_reg})); end
            S_HD:    begin mul_a = prod_reg[31:0];    mul_b = TURN_TO_ANGLE; end
            S_CF:    begin mul_a = 32'(cs_reg);       mul_b = 27'(fwd_reg); end
            S_SS:    begin mul_a = 32'(sn_reg);       mul_b = 27'(side_reg); end
            S_SF:    begin mul_a = 32'(sn_reg);       mul_b = 27'(fwd_reg); end
            S_CS:    begin mul_a = 32'(cs_reg);       mul_b = 27'(side_reg); end
            S_XD:    begin mul_a = vx_reg;            mul_b = 27'($signed({1'b0, dt_reg})); end
            S_YD:    begin mul_a = vy_reg;            mul_b = 27'($signed({1'b0, dt_reg})); end
            S_ZD:    begin mul_a = 32'(up_reg);       mul_b = 27'($signed({1'b0, dt_reg})); end
            default: begin mul_a = '0;                mul_b = '0; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 59'(mul_a) * 59'(mul_b);
    end

    assign prod_rnd24 = prod_reg + 59'sd8388608;
    assign prod_rnd14 = prod_reg + 59'sd8192;
    assign head_next  = head_reg + prod_rnd24[55:24];
    assign pz_sum     = 34'(pz_reg) + prod_reg[33:0];

    // The full heading is folded into the CORDIC range; results flip sign.
    assign ang_full = 34'($signed(head_next));
    assign fold_hi  = ang_full > 34'sd1073741824;
    assign fold_lo  = ang_full < -34'sd1073741824;
    assign ang_half = 34'($signed(head_reg)) >>> 1;

    always_comb
    begin
        cordic_start = 1'b0;
        cordic_angle = ang_half;
        if (state_reg == S_HACC)
        begin
            cordic_start = 1'b1;
            if (fold_hi)
                cordic_angle = ang_full - 34'sd2147483648;
            else if (fold_lo)
                cordic_angle = ang_full + 34'sd2147483648;
            else
                cordic_angle = ang_full;
        end
        else if (state_reg == S_CLAMP)
        begin
            cordic_start = 1'b1;
        end
    end

    ppi_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (cordic_angle),
        .done  (cordic_done),
        .sin_q (c_sin),
        .cos_q (c_cos)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid && command) state_next = S_TD;
            S_TD:    state_next = S_HD;
            S_HD:    state_next = S_HACC;
            S_HACC:  state_next = S_ROT;
            S_ROT:   if (cordic_done) state_next = S_CF;
            S_CF:    state_next = S_SS;
            S_SS:    state_next = S_SF;
            S_SF:    state_next = S_CS;
            S_CS:    state_next = S_XD;
            S_XD:    state_next = S_YD;
            S_YD:    state_next = S_ZD;
            S_ZD:    state_next = S_CLAMP;
            S_CLAMP: state_next = S_HALF;
            S_HALF:  if (cordic_done) state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg  <= -16'sd8192;
            max_x_reg  <= 16'sd12288;
            min_y_reg  <= -16'sd8192;
            max_y_reg  <= 16'sd8192;
            min_z_reg  <= 16'sd1638;
            max_z_reg  <= 16'sd10240;
            home_z_reg <= 16'sd4915;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MIN_X:  min_x_reg  <= cfg_data;
                REG_MAX_X:  max_x_reg  <= cfg_data;
                REG_MIN_Y:  min_y_reg  <= cfg_data;
                REG_MAX_Y:  max_y_reg  <= cfg_data;
                REG_MIN_Z:  min_z_reg  <= cfg_data;
                REG_MAX_Z:  max_z_reg  <= cfg_data;
                REG_HOME_Z: home_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Pose and held command state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg  <= '0;
            side_reg <= '0;
            up_reg   <= '0;
            turn_reg <= '0;
            home_reg <= 1'b0;
            px_reg   <= {HOME_X, 16'd0};
            py_reg   <= {HOME_Y, 16'd0};
            pz_reg   <= {16'sd4915, 16'd0};
            head_reg <= '0;
        end
        else if (state_reg == S_IDLE && in_valid)
        begin
            if (!command)
            begin
                fwd_reg  <= vel_fwd;
                side_reg <= vel_side;
                up_reg   <= vel_up;
                turn_reg <= turn_rate;
                home_reg <= roll_rate > HOME_LEVEL;
            end
            else if (home_reg)
            begin
                fwd_reg  <= '0;
                side_reg <= '0;
                up_reg   <= '0;
                turn_reg <= '0;
                home_reg <= 1'b0;
                px_reg   <= {HOME_X, 16'd0};
                py_reg   <= {HOME_Y, 16'd0};
                pz_reg   <= {home_z_reg, 16'd0};
                head_reg <= '0;
            end
        end
        else if (state_reg == S_HACC)
        begin
            head_reg <= head_next;
        end
        else if (state_reg == S_CLAMP)
        begin
            px_reg <= clamp_axis(sx_reg, min_x_reg, max_x_reg);
            py_reg <= clamp_axis(sy_reg, min_y_reg, max_y_reg);
            pz_reg <= clamp_axis(pz_sum, min_z_reg, max_z_reg);
        end
    end

    // Working registers of one tick.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && command)
        begin
            if (elapsed == 16'd0 || elapsed > DT_LIMIT)
                dt_reg <= DT_DEFAULT;
            else
                dt_reg <= elapsed[14:0];
        end
        if (state_reg == S_HACC)
            neg_reg <= fold_hi || fold_lo;
        if (state_reg == S_ROT && cordic_done)
        begin
            sn_reg <= neg_reg ? -c_sin : c_sin;
            cs_reg <= neg_reg ? -c_cos : c_cos;
        end
        if (state_reg == S_SS)
            vx_reg <= prod_reg[31:0];
        if (state_reg == S_SF)
            vx_reg <= vx_reg - prod_reg[31:0];
        if (state_reg == S_CS)
            vy_reg <= prod_reg[31:0];
        if (state_reg == S_XD)
            vy_reg <= vy_reg + prod_reg[31:0];
        if (state_reg == S_YD)
            sx_reg <= 34'(px_reg) + prod_rnd14[47:14];
        if (state_reg == S_ZD)
            sy_reg <= 34'(py_reg) + prod_rnd14[47:14];
        if (state_reg == S_HALF && cordic_done)
        begin
            quat_z <= c_sin;
            quat_w <= c_cos;
        end
    end

    assign pos_x       = px_reg[31:16];
    assign pos_y       = py_reg[31:16];
    assign pos_z       = pz_reg[31:16];
    assign heading_out = head_reg[31:16];

endmodule

// ----- rtl/ppi_checker.sv -----
// Port-level checks for the planar pose integrator and the bind that attaches
// them. Depends on the planar_pose_integrator port list.
module ppi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               command,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] pos_x,
    input logic signed [15:0] quat_w
);
    // A finished result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x))
        else $error("result changed while stalled");

    // One item at a time: no input is taken while a result is shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // A command item never yields a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !command |=> !out_valid)
        else $error("result after command item");

    // The half-angle cosine is never negative.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !quat_w[15])
        else $error("negative quat_w");
endmodule

bind planar_pose_integrator ppi_checker u_ppi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pos_x     (pos_x),
    .quat_w    (quat_w)
);

// ----- tb/planar_pose_integrator_tb.sv -----
// Self-checking testbench for planar_pose_integrator: directed table, then random
// command and tick items checked against an in-bench pose predictor. Needs ppi_pkg.
module planar_pose_integrator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ppi_pkg::*;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic command = CMD_LOAD;
    logic signed [15:0] vel_fwd = '0, vel_side = '0, vel_up = '0;
    logic signed [15:0] turn_rate = '0, roll_rate = '0;
    logic [15:0] elapsed = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] pos_x, pos_y, pos_z, quat_z, quat_w;
    logic [15:0] heading_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    reg_index_t cfg_index = REG_MIN_X;
    logic signed [15:0] cfg_data = '0;

    typedef struct packed {
        logic signed [15:0] x, y, z;
        logic [15:0] hd;
        logic signed [15:0] qz, qw;
    } pose_t;

    typedef struct {
        logic cmd;
        logic signed [15:0] fwd, side, up, turn, roll;
        logic [15:0] dt;
        logic known;
        pose_t pose;
    } stim_row_t;

    pose_t pose_queue[$];
    int mismatches = 0;

    // predictor state
    longint bnd_lo[3], bnd_hi[3], home_alt;
    longint cmd_fwd, cmd_side, cmd_up, cmd_turn;
    bit go_home;
    longint pos_acc[3];
    logic [31:0] heading;

    planar_pose_integrator u_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint to_q14(longint v);
        longint r;
        r = round_shift(v, 16);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    task automatic cordic_rotate(input longint a, output longint sn, output longint cs);
        longint x, y, z, dx, dy;
        x = CORDIC_GAIN;
        y = 0;
        z = a;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(ppi_atan(i[3:0]));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(ppi_atan(i[3:0]));
            end
        end
        sn = to_q14(y);
        cs = to_q14(x);
    endtask

    function automatic longint angle_signed(logic [31:0] h);
        return longint'(signed'(h));
    endfunction

    function automatic longint clamp_to_box(longint p, longint lo, longint hi);
        if (p < lo * 65536) return lo * 65536;
        if (p > hi * 65536) return hi * 65536;
        return p;
    endfunction

    task automatic reset_pose_model();
        bnd_lo = '{-8192, -8192, 1638};
        bnd_hi = '{12288, 8192, 10240};
        home_alt = 4915;
        {cmd_fwd, cmd_side, cmd_up, cmd_turn} = '0;
        go_home = 0;
        pos_acc = '{0, 0, 4915 * 65536};
        heading = '0;
    endtask

    task automatic model_config(reg_index_t idx, logic signed [15:0] v);
        case (idx)
            REG_MIN_X: bnd_lo[0] = v;
            REG_MAX_X: bnd_hi[0] = v;
            REG_MIN_Y: bnd_lo[1] = v;
            REG_MAX_Y: bnd_hi[1] = v;
            REG_MIN_Z: bnd_lo[2] = v;
            REG_MAX_Z: bnd_hi[2] = v;
            REG_HOME_Z: home_alt = v;
            default: ;
        endcase
    endtask

    task automatic predict_tick(input logic [15:0] dt_in, output pose_t p);
        longint dt, sn, cs, vx, vy, a, qz, qw;
        longint nxt[3];
        bit neg;
        dt = dt_in;
        if (dt == 0 || dt > 16384) dt = DT_DEFAULT;
        if (go_home)
        begin
            pos_acc = '{0, 0, home_alt * 65536};
            heading = '0;
            {cmd_fwd, cmd_side, cmd_up, cmd_turn} = '0;
            go_home = 0;
        end
        heading = heading + 32'(round_shift(cmd_turn * dt * TURN_TO_ANGLE, 24));
        // Fold the heading into the CORDIC range and flip the signs back after.
        a = angle_signed(heading);
        neg = 0;
        if (a > (longint'(1) << 30))
        begin
            a -= longint'(1) << 31; neg = 1;
        end
        else if (a < -(longint'(1) << 30))
        begin
            a += longint'(1) << 31; neg = 1;
        end
        cordic_rotate(a, sn, cs);
        if (neg)
        begin
            sn = -sn; cs = -cs;
        end
        vx = cs * cmd_fwd - sn * cmd_side;
        vy = sn * cmd_fwd + cs * cmd_side;
        nxt[0] = pos_acc[0] + round_shift(vx * dt, 14);
        nxt[1] = pos_acc[1] + round_shift(vy * dt, 14);
        nxt[2] = pos_acc[2] + cmd_up * dt;
        for (int k = 0; k < 3; k++)
            pos_acc[k] = clamp_to_box(nxt[k], bnd_lo[k], bnd_hi[k]);
        cordic_rotate(floor_shift(angle_signed(heading), 1), qz, qw);
        p.x = 16'(floor_shift(pos_acc[0], 16));
        p.y = 16'(floor_shift(pos_acc[1], 16));
        p.z = 16'(floor_shift(pos_acc[2], 16));
        p.hd = heading[31:16];
        p.qz = 16'(qz);
        p.qw = 16'(qw);
    endtask

    // Valid stays high across items sent with no gap; it drops only for a gap or in drain.
    task automatic send_item(input stim_row_t r);
        pose_t p;
        int gap;
        gap = $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (r.cmd == CMD_LOAD)
        begin
            cmd_fwd = r.fwd; cmd_side = r.side; cmd_up = r.up; cmd_turn = r.turn;
            go_home = r.roll > HOME_LEVEL;
        end
        else
        begin
            predict_tick(r.dt, p);
            if (r.known && p != r.pose)
                $display("table row disagrees with predictor: %p vs %p", r.pose, p);
            pose_queue.push_back(r.known ? r.pose : p);
        end
        in_valid <= 1'b1;
        command <= r.cmd;
        vel_fwd <= r.fwd; vel_side <= r.side; vel_up <= r.up;
        turn_rate <= r.turn; roll_rate <= r.roll; elapsed <= r.dt;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic signed [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        model_config(idx, v);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pose_queue.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    function automatic stim_row_t load_row(int f, int s, int u, int t, int r);
        stim_row_t x;
        x = '{CMD_LOAD, 16'(f), 16'(s), 16'(u), 16'(t), 16'(r), 16'($urandom), 0, '{default: 0}};
        return x;
    endfunction

    function automatic stim_row_t tick_row(int dt);
        stim_row_t x;
        x = '{CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'(dt), 0, '{default: 0}};
        return x;
    endfunction

    function automatic stim_row_t known_tick(int dt, int px, int py, int pz);
        stim_row_t x;
        x = tick_row(dt);
        x.known = 1;
        x.pose = '{16'(px), 16'(py), 16'(pz), 16'd0, 16'sd0, 16'sd16384};
        return x;
    endfunction

    // Output side: random stalls, compare against the oldest expected pose.
    always @(posedge clk)
    begin
        pose_t exp_p;
        if (out_valid && out_ready)
        begin
            if (pose_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected pose item %p", {pos_x, pos_y});
            end
            else
            begin
                exp_p = pose_queue.pop_front();
                if (exp_p.x !== pos_x || exp_p.y !== pos_y || exp_p.z !== pos_z ||
                    exp_p.hd !== heading_out || exp_p.qz !== quat_z ||
                    exp_p.qw !== quat_w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pose mismatch exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                                 exp_p.x, exp_p.y, exp_p.z, exp_p.hd, exp_p.qz, exp_p.qw,
                                 pos_x, pos_y, pos_z, heading_out, quat_z, quat_w);
                end
            end
        end
    end

    initial
    begin
        int stall;
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, 15);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        stim_row_t table_rows[$];
        stim_row_t r;
        int kind;
        reset_pose_model();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: idle tick at reset pose, out-of-range and extreme dt,
        // extreme speeds into clamps, home request.
        table_rows.push_back(known_tick(0, 0, 0, 4915));
        table_rows.push_back(known_tick(65535, 0, 0, 4915));
        table_rows.push_back(known_tick(16384, 0, 0, 4915));
        table_rows.push_back(load_row(32767, 32767, 32767, 32767, 0));
        table_rows.push_back(tick_row(16384));
        table_rows.push_back(tick_row(1));
        table_rows.push_back(load_row(-32768, -32768, -32768, -32768, -32768));
        table_rows.push_back(tick_row(16385));
        table_rows.push_back(tick_row(16384));
        table_rows.push_back(load_row(0, 0, 0, 0, 2048));
        table_rows.push_back(tick_row(100));
        table_rows.push_back(load_row(4096, -4096, 0, 12868, 2049));
        table_rows.push_back(known_tick(3277, 0, 0, 4915));
        table_rows.push_back(load_row(12000, 3000, -500, -20000, 32767));
        table_rows.push_back(tick_row(8000));
        table_rows.push_back(load_row(12000, 3000, 500, 25736, 0));
        for (int i = 0; i < 6; i++) table_rows.push_back(tick_row(16384));
        foreach (table_rows[i]) send_item(table_rows[i]);
        drain();

        // Inverted and extreme bounds, then home altitude at the edges.
        write_reg(REG_MIN_X, 16'sd4096);
        write_reg(REG_MAX_X, -16'sd4096);
        write_reg(REG_MIN_Y, 16'sh8000);
        write_reg(REG_MAX_Y, 16'sd32767);
        write_reg(REG_MIN_Z, 16'sh8000);
        write_reg(REG_MAX_Z, 16'sd32767);
        write_reg(REG_HOME_Z, 16'sd32767);
        write_reg(REG_NONE, 16'sd1234);

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int i = 0; i < 130; i++)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 3)
                    r = load_row($urandom, $urandom, $urandom, $urandom,
                                 $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 2048));
                else
                    r = tick_row($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 16384));
                send_item(r);
            end
            drain();
            write_reg(REG_MIN_X, 16'($urandom_range(0, 1) ? -32768 : $urandom_range(0, 65535)));
            write_reg(REG_MAX_X, 16'($urandom_range(0, 1) ? 32767 : $urandom_range(0, 65535)));
            write_reg(REG_MIN_Y, 16'($urandom));
            write_reg(REG_MAX_Y, 16'($urandom));
            write_reg(REG_MIN_Z, 16'(-$urandom_range(0, 20000)));
            write_reg(REG_MAX_Z, 16'($urandom_range(0, 20000)));
            write_reg(REG_HOME_Z, 16'(ph == 0 ? -32768 : $urandom));
        end
        drain();
        if (mismatches == 0 && pose_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
